[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

  // Default screen geometry
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // Character and attribute codes
  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  // Store operation issued by the controller for the current cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_EXEC,
    OP_COPY,
    OP_BLANK
  } op_e;

  // Sweep counter control
  typedef enum logic [1:0] {
    CNT_RUN,
    CNT_COPY_START,
    CNT_BLANK_START
  } cnt_init_e;

  typedef struct packed {
    op_e       op;
    cnt_init_e cnt_init;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic cnt_end;
  } sts_t;

endpackage

[hdl/tcw_datapath.sv]
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              func_i,
  input  logic [7:0]        char_code_i,
  input  logic [4:0]        read_row_i,
  input  logic [6:0]        read_col_i,
  input  tcw_pkg::cmd_t     cmd_i,
  output tcw_pkg::sts_t     sts_o,
  output logic [15:0]       cell_value_o,
  output logic [6:0]        cursor_col_o,
  output logic [4:0]        cursor_line_o,
  output logic              scrolled_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned LW    = $clog2(ROWS);

  // Screen store
  logic [15:0] mem_q [CELLS];
  logic [15:0] rdata_q;

  // Configuration and latched request
  logic [7:0]  attr_q;
  logic        func_q;
  logic [7:0]  char_q;
  logic [4:0]  read_row_q;
  logic [6:0]  read_col_q;

  // Cursor and sweep counter
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [LW-1:0] cur_line_q, cur_line_d;
  logic [AW-1:0] cnt_q;

  // Write stage: one store write per cycle, registered here before it reaches the store
  logic          pend_v_q, pend_v_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          pend_rd_q, pend_rd_d;
  logic [15:0]   pend_word_q, pend_word_d;

  // Result registers
  logic [15:0]   cell_value_q;
  logic [6:0]    cursor_col_q;
  logic [4:0]    cursor_line_q;
  logic          scrolled_q, scrolled_d;
  logic          scrolled_out_q;

  logic          in_range;
  logic [AW-1:0] item_addr;
  logic [AW-1:0] cur_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          is_lf;
  logic [CW:0]   col_inc;
  logic [LW:0]   line_inc;
  logic          new_line;
  logic          wrap;

  // Address decode for reads and the cursor cell
  assign in_range  = ({2'b00, read_row_q} < 7'(ROWS)) && ({1'b0, read_col_q} < 8'(COLUMNS));
  assign item_addr = AW'(read_row_q) * AW'(COLUMNS) + AW'(read_col_q);
  assign cur_addr  = AW'(cur_line_q) * AW'(COLUMNS) + AW'(cur_col_q);

  // Cursor advance
  assign is_lf    = (char_q == tcw_pkg::LINE_FEED);
  assign col_inc  = {1'b0, cur_col_q} + (CW+1)'(1);
  assign line_inc = {1'b0, cur_line_q} + (LW+1)'(1);
  assign new_line = is_lf || (col_inc >= (CW+1)'(COLUMNS));
  assign wrap     = new_line && (line_inc >= (LW+1)'(ROWS));

  assign sts_o.need_scroll = !func_q && wrap;
  assign sts_o.cnt_end     = (cnt_q == AW'(CELLS - 1));

  always_comb begin
    cur_col_d  = cur_col_q;
    cur_line_d = cur_line_q;
    scrolled_d = scrolled_q;
    if (cmd_i.op == tcw_pkg::OP_EXEC) begin
      scrolled_d = !func_q && wrap;
      if (!func_q) begin
        if (new_line) begin
          cur_col_d  = '0;
          cur_line_d = wrap ? LW'(ROWS - 1) : line_inc[LW-1:0];
        end else begin
          cur_col_d = col_inc[CW-1:0];
        end
      end
    end
  end

  // Store read port
  assign rd_en   = ((cmd_i.op == tcw_pkg::OP_EXEC) && func_q && in_range) ||
                   (cmd_i.op == tcw_pkg::OP_COPY);
  assign rd_addr = (cmd_i.op == tcw_pkg::OP_COPY) ? cnt_q : item_addr;

  // Write issue
  always_comb begin
    pend_v_d    = 1'b0;
    pend_addr_d = cnt_q;
    pend_rd_d   = 1'b0;
    pend_word_d = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
    case (cmd_i.op)
      tcw_pkg::OP_CLEAR: begin
        pend_v_d = 1'b1;
      end
      tcw_pkg::OP_EXEC: begin
        pend_v_d    = !func_q && !is_lf;
        pend_addr_d = cur_addr;
        pend_word_d = {attr_q, char_q};
      end
      tcw_pkg::OP_COPY: begin
        pend_v_d    = 1'b1;
        pend_addr_d = cnt_q - AW'(COLUMNS);
        pend_rd_d   = 1'b1;
      end
      tcw_pkg::OP_BLANK: begin
        pend_v_d    = 1'b1;
        pend_word_d = {attr_q, tcw_pkg::BLANK_CHAR};
      end
      default: begin
        pend_v_d = 1'b0;
      end
    endcase
  end

  // Store
  always_ff @(posedge clk_i) begin
    if (pend_v_q) begin
      mem_q[pend_addr_q] <= pend_rd_q ? rdata_q : pend_word_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q     <= tcw_pkg::RESET_ATTR;
      cur_col_q  <= '0;
      cur_line_q <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      cur_col_q  <= cur_col_d;
      cur_line_q <= cur_line_d;
      scrolled_q <= scrolled_d;
      pend_v_q   <= pend_v_d;
      case (cmd_i.cnt_init)
        tcw_pkg::CNT_COPY_START:  cnt_q <= AW'(COLUMNS);
        tcw_pkg::CNT_BLANK_START: cnt_q <= AW'((ROWS - 1) * COLUMNS);
        default: begin
          if (cmd_i.op == tcw_pkg::OP_CLEAR || cmd_i.op == tcw_pkg::OP_COPY ||
              cmd_i.op == tcw_pkg::OP_BLANK) begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_rd_q   <= pend_rd_d;
    pend_word_q <= pend_word_d;
    if (cmd_i.op == tcw_pkg::OP_LOAD) begin
      func_q     <= func_i;
      char_q     <= char_code_i;
      read_row_q <= read_row_i;
      read_col_q <= read_col_i;
    end
    if (cmd_i.load_out) begin
      cell_value_q   <= (func_q && in_range) ? rdata_q : 16'h0000;
      cursor_col_q   <= 7'(cur_col_q);
      cursor_line_q  <= 5'(cur_line_q);
      scrolled_out_q <= scrolled_q;
    end
  end

  assign cell_value_o  = cell_value_q;
  assign cursor_col_o  = cursor_col_q;
  assign cursor_line_o = cursor_line_q;
  assign scrolled_o    = scrolled_out_q;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < (CW+1)'(COLUMNS)) && ({1'b0, cur_line_q} < (LW+1)'(ROWS)))
    else $error("cursor left the screen");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> ({1'b0, pend_addr_q} < (AW+1)'(CELLS)))
    else $error("store write outside the screen");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_v_q && rd_en) |-> (pend_addr_q != rd_addr))
    else $error("store read collides with pending write");
`endif

endmodule

[hdl/tcw_ctrl.sv]
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tcw_pkg::cmd_t cmd_o,
  input  tcw_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_BLANK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Commands and next state
  always_comb begin
    state_d         = state_q;
    cmd_o.op        = tcw_pkg::OP_NONE;
    cmd_o.cnt_init  = tcw_pkg::CNT_RUN;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = tcw_pkg::OP_CLEAR;
        if (sts_i.cnt_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = tcw_pkg::OP_LOAD;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.op = tcw_pkg::OP_EXEC;
        if (sts_i.need_scroll) begin
          cmd_o.cnt_init = tcw_pkg::CNT_COPY_START;
          state_d        = ST_COPY;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_COPY: begin
        cmd_o.op = tcw_pkg::OP_COPY;
        if (sts_i.cnt_end) begin
          cmd_o.cnt_init = tcw_pkg::CNT_BLANK_START;
          state_d        = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd_o.op = tcw_pkg::OP_BLANK;
        if (sts_i.cnt_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while waiting");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_EXEC))
    else $error("accepted request not executed");

  a_scroll_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && sts_i.need_scroll) |=> (state_q == ST_COPY))
    else $error("scroll not started");

  a_copy_to_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && sts_i.cnt_end) |=> (state_q == ST_BLANK))
    else $error("bottom row not blanked after copy");
`endif

endmodule

[hdl/text_console_writer.sv]
`timescale 1ns / 1ps

// Text console with scroll. Holds a ROWS x COLUMNS screen of 16-bit cells
// (attribute over character) in a single-port-write, single-port-read store,
// plus a cursor. After reset the block sweeps the store to blanks (0x0F20),
// one cell per cycle; input stalls during that sweep while attribute writes
// are still taken. A read request or a put that does not scroll passes
// through accept, execute and result steps before the next acceptance; the
// result step waits while a held result is stalled. A put that scrolls adds
// a walk of the store, one cell per cycle, copying rows up and then blanking
// the bottom row. Each request gives one result, held in an output register,
// so the next request is taken while a result waits.
module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  char_code_i,
  input  logic [4:0]  read_row_i,
  input  logic [6:0]  read_col_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] cell_value_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_line_o,
  output logic        scrolled_o
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .read_row_i    (read_row_i),
    .read_col_i    (read_col_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cell_value_o  (cell_value_o),
    .cursor_col_o  (cursor_col_o),
    .cursor_line_o (cursor_line_o),
    .scrolled_o    (scrolled_o)
  );

endmodule

[tb/tb_text_console_writer.sv]
`timescale 1ns / 1ps

module tb_text_console_writer;

  localparam int unsigned COLUMNS   = tcw_pkg::COLUMNS_DEF;
  localparam int unsigned ROWS      = tcw_pkg::ROWS_DEF;
  localparam int unsigned SWEEP     = ROWS * COLUMNS;
  localparam int unsigned SETTLE    = SWEEP + 32;
  localparam int unsigned LIMIT     = 20000000;
  localparam int unsigned N_SCRIPT  = 21;

  localparam bit FUNC_PUT  = 1'b0;
  localparam bit FUNC_READ = 1'b1;

  localparam logic [15:0] BLANK_CELL = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
  localparam logic [15:0] NO_CELL    = 16'h0000;

  typedef struct packed {
    bit         fn;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } console_req_t;

  typedef struct packed {
    logic [15:0] cell_val;
    logic [6:0]  ccol;
    logic [4:0]  cline;
    logic        scrolled;
  } console_report_t;

  typedef struct packed {
    console_req_t    rq;
    bit              typed;
    console_report_t rep;
  } script_row_t;

  // DUT ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        func_i      = 1'b0;
  logic [7:0]  char_code_i = 8'h00;
  logic [4:0]  read_row_i  = 5'd0;
  logic [6:0]  read_col_i  = 7'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] cell_value_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_line_o;
  logic        scrolled_o;

  // Shadow copy of the console
  logic [15:0] shadow_screen [SWEEP];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  shadow_attr;

  console_report_t awaited_reports [$];
  script_row_t     script [N_SCRIPT];

  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          gap_pct = 15;
  int          stall_pct = 15;
  int          stall_left = 0;
  bit          quiet_run = 1'b0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_value_o (cell_value_o),
    .cursor_col_o (cursor_col_o),
    .cursor_line_o(cursor_line_o),
    .scrolled_o   (scrolled_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAIL text_console_writer");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (quiet_run || stall_pct == 0) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Shadow console: new line, scrolling at the bottom
  function automatic bit start_row();
    int unsigned k;
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    cur_row = ROWS - 1;
    for (k = 0; k < (ROWS - 1) * COLUMNS; k++) shadow_screen[k] = shadow_screen[k + COLUMNS];
    for (k = 0; k < COLUMNS; k++)
      shadow_screen[(ROWS - 1) * COLUMNS + k] = {shadow_attr, tcw_pkg::BLANK_CHAR};
    return 1'b1;
  endfunction

  // Shadow console: one request in, one report out
  function automatic console_report_t console_apply(input console_req_t rq);
    console_report_t rep;
    rep = '0;
    if (rq.fn == FUNC_READ) begin
      if (rq.row < ROWS && rq.col < COLUMNS)
        rep.cell_val = shadow_screen[rq.row * COLUMNS + rq.col];
    end else if (rq.ch == tcw_pkg::LINE_FEED) begin
      rep.scrolled = start_row();
    end else begin
      shadow_screen[cur_row * COLUMNS + cur_col] = {shadow_attr, rq.ch};
      cur_col++;
      if (cur_col >= COLUMNS) rep.scrolled = start_row();
    end
    rep.ccol  = cur_col[6:0];
    rep.cline = cur_row[4:0];
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    console_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got cell 0x%0h col %0d line %0d scr %0b",
                 $time, cell_value_o, cursor_col_o, cursor_line_o, scrolled_o);
      end else begin
        want = awaited_reports.pop_front();
        check_field("cell_value", 32'(want.cell_val), 32'(cell_value_o));
        check_field("cursor_col", 32'(want.ccol), 32'(cursor_col_o));
        check_field("cursor_line", 32'(want.cline), 32'(cursor_line_o));
        check_field("scrolled", 32'(want.scrolled), 32'(scrolled_o));
      end
    end
  end

  task automatic write_attr(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_attr = value;
  endtask

  // Issue one request; optionally idle or drain first
  task automatic send_request(input console_req_t rq, input bit typed, input console_report_t typed_rep,
                              input bit drain_first);
    console_report_t rep;
    int gap;
    gap = 0;
    if (!quiet_run && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 6);
    if (gap > 0 || (drain_first && awaited_reports.size() != 0)) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain_first) while (awaited_reports.size() != 0) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= rq.fn;
    char_code_i <= rq.ch;
    read_row_i  <= rq.row;
    read_col_i  <= rq.col;
    do @(posedge clk_i); while (in_stall_o);
    rep = console_apply(rq);
    awaited_reports.push_back(typed ? typed_rep : rep);
  endtask

  // Drop valid, let all results and any scroll finish
  task automatic close_phase();
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random traffic: reads biased to the screen, puts with tunable line feed rate
  task automatic run_phase(input int count, input int read_pct, input int lf_pct);
    console_req_t rq;
    int n;
    for (n = 0; n < count; n++) begin
      rq.fn  = ($urandom_range(0, 99) < read_pct) ? FUNC_READ : FUNC_PUT;
      rq.ch  = 8'($urandom_range(0, 255));
      rq.row = 5'($urandom_range(0, 31));
      rq.col = 7'($urandom_range(0, 127));
      if (rq.fn == FUNC_READ) begin
        if ($urandom_range(0, 99) < 85) begin
          rq.col = 7'($urandom_range(0, COLUMNS - 1));
          case ($urandom_range(0, 9))
            0, 1: rq.row = cur_row[4:0];
            2:    rq.row = 5'(ROWS - 1);
            default: rq.row = 5'($urandom_range(0, ROWS - 1));
          endcase
        end
      end else if ($urandom_range(0, 99) < lf_pct) begin
        rq.ch = tcw_pkg::LINE_FEED;
      end
      send_request(rq, 1'b0, '0, $urandom_range(0, 99) < 2);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < SWEEP; i++) shadow_screen[i] = BLANK_CELL;
    cur_col     = 0;
    cur_row     = 0;
    shadow_attr = tcw_pkg::RESET_ATTR;

    // Directed: reset contents, out-of-range reads, ignored fields, line feed
    script = '{
      '{'{FUNC_READ, 8'h00, 5'd0,  7'd0},   1'b1, '{BLANK_CELL, 7'd0, 5'd0, 1'b0}},
      '{'{FUNC_READ, 8'hFF, 5'd24, 7'd79},  1'b1, '{BLANK_CELL, 7'd0, 5'd0, 1'b0}},
      '{'{FUNC_READ, 8'h00, 5'd25, 7'd0},   1'b1, '{NO_CELL,    7'd0, 5'd0, 1'b0}},
      '{'{FUNC_READ, 8'h00, 5'd0,  7'd80},  1'b1, '{NO_CELL,    7'd0, 5'd0, 1'b0}},
      '{'{FUNC_READ, tcw_pkg::LINE_FEED, 5'd31, 7'd127}, 1'b1, '{NO_CELL, 7'd0, 5'd0, 1'b0}},
      '{'{FUNC_PUT,  8'h41, 5'd31, 7'd127}, 1'b1, '{NO_CELL,    7'd1, 5'd0, 1'b0}},
      '{'{FUNC_PUT,  8'h00, 5'd0,  7'd0},   1'b1, '{NO_CELL,    7'd2, 5'd0, 1'b0}},
      '{'{FUNC_PUT,  8'hFF, 5'd0,  7'd0},   1'b1, '{NO_CELL,    7'd3, 5'd0, 1'b0}},
      '{'{FUNC_PUT,  tcw_pkg::LINE_FEED, 5'd0, 7'd0}, 1'b1, '{NO_CELL, 7'd0, 5'd1, 1'b0}},
      '{'{FUNC_READ, 8'h55, 5'd0,  7'd0},   1'b1, '{16'h0F41,   7'd0, 5'd1, 1'b0}},
      '{'{FUNC_READ, 8'h00, 5'd0,  7'd1},   1'b1, '{16'h0F00,   7'd0, 5'd1, 1'b0}},
      '{'{FUNC_READ, 8'h00, 5'd0,  7'd2},   1'b1, '{16'h0FFF,   7'd0, 5'd1, 1'b0}},
      '{'{FUNC_READ, 8'h00, 5'd0,  7'd3},   1'b1, '{BLANK_CELL, 7'd0, 5'd1, 1'b0}},
      '{'{FUNC_READ, 8'h00, 5'd1,  7'd0},   1'b1, '{BLANK_CELL, 7'd0, 5'd1, 1'b0}},
      '{'{FUNC_PUT,  tcw_pkg::LINE_FEED, 5'd0, 7'd0}, 1'b1, '{NO_CELL, 7'd0, 5'd2, 1'b0}},
      '{'{FUNC_PUT,  8'h7E, 5'd12, 7'd40},  1'b0, '0},
      '{'{FUNC_PUT,  8'h80, 5'd7,  7'd3},   1'b0, '0},
      '{'{FUNC_READ, 8'h00, 5'd2,  7'd0},   1'b0, '0},
      '{'{FUNC_READ, tcw_pkg::LINE_FEED, 5'd2, 7'd1}, 1'b0, '0},
      '{'{FUNC_READ, 8'h00, 5'd24, 7'd0},   1'b0, '0},
      '{'{FUNC_READ, 8'h00, 5'd0,  7'd79},  1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_attr(tcw_pkg::RESET_ATTR);

    for (i = 0; i < N_SCRIPT; i++) send_request(script[i].rq, script[i].typed, script[i].rep, 1'b0);
    close_phase();

    // Random phases under different attributes and idling
    write_attr(8'h00);
    gap_pct = 20; stall_pct = 20;
    run_phase(220, 40, 10);
    close_phase();

    write_attr(8'hFF);
    gap_pct = 30; stall_pct = 40;
    run_phase(220, 35, 2);
    close_phase();

    write_attr(8'($urandom_range(0, 255)));
    gap_pct = 10; stall_pct = 0;
    run_phase(220, 50, 15);
    close_phase();

    write_attr(8'($urandom_range(0, 255)));
    gap_pct = 40; stall_pct = 30;
    run_phase(200, 40, 6);
    close_phase();

    // Last stretch at full rate
    write_attr(8'($urandom_range(0, 255)));
    quiet_run = 1'b1;
    run_phase(220, 40, 8);
    close_phase();

    if (mismatches == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/tcw_pkg.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
tb/tb_text_console_writer.sv
